>>> src/ltt_pkg.sv
package ltt_pkg;

  localparam int SLOTS = 16;
  localparam int MAX_RESULTS = 16;

  localparam int PINS_W = 16;
  localparam int PORT_W = 4;
  localparam int COUNT_W = 32;

  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W = $clog2(SLOTS + 1);
  localparam int NUM_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic {
    FUNC_REQ  = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef enum logic {
    LEVEL_ON  = 1'b0,
    LEVEL_OFF = 1'b1
  } level_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  typedef struct packed {
    logic [PINS_W-1:0]  pins;
    logic [PORT_W-1:0]  port;
    logic [COUNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              vld;
    level_e            level;
    logic [PORT_W-1:0] port;
    logic [PINS_W-1:0] pins;
  } act_t;

  typedef struct packed {
    act_t act;
    logic fin;
  } ev_t;

endpackage

>>> src/ltt_ram.sv
module ltt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ltt_ctrl.sv
module ltt_ctrl import ltt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               func_i,
  input  logic [PORT_W-1:0]  port_i,
  input  logic [PINS_W-1:0]  pin_mask_i,
  input  logic [COUNT_W-1:0] delay_i,
  output logic               re_o,
  output logic [SLOT_AW-1:0] raddr_o,
  input  entry_t             rdata_i,
  output logic               we_o,
  output logic [SLOT_AW-1:0] waddr_o,
  output entry_t             wdata_o,
  output ev_t                ev_o
);

  state_e              state_q, state_d;
  logic [FILL_W-1:0]   idx_q, idx_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [NUM_W-1:0]    num_q, num_d;
  logic                vld_q, vld_d;
  logic [SLOT_AW-1:0]  eidx_q, eidx_d;
  func_e               func_q, func_d;
  logic [PORT_W-1:0]   port_q, port_d;
  logic [PINS_W-1:0]   pins_q, pins_d;
  logic [COUNT_W-1:0]  delay_q, delay_d;
  logic                issue;
  logic                match;

  assign busy = (state_q != ST_IDLE);
  assign issue = (idx_q < fill_q);
  assign match = (rdata_i.pins == pins_q) && (rdata_i.port == port_q);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    fill_d  = fill_q;
    num_d   = num_q;
    vld_d   = 1'b0;
    eidx_d  = eidx_q;
    func_d  = func_q;
    port_d  = port_q;
    pins_d  = pins_q;
    delay_d = delay_q;
    re_o    = 1'b0;
    raddr_o = idx_q[SLOT_AW-1:0];
    we_o    = 1'b0;
    waddr_o = eidx_q;
    wdata_o = rdata_i;
    ev_o    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start && (func_i == FUNC_TICK || pin_mask_i != '0)) begin
          state_d = ST_WALK;
          idx_d   = '0;
          num_d   = '0;
          func_d  = func_e'(func_i);
          port_d  = port_i;
          pins_d  = pin_mask_i;
          delay_d = delay_i;
        end
      end
      ST_WALK: begin
        if (issue) begin
          re_o   = 1'b1;
          idx_d  = idx_q + FILL_W'(1);
          vld_d  = 1'b1;
          eidx_d = idx_q[SLOT_AW-1:0];
        end
        if (vld_q) begin
          if (func_q == FUNC_REQ) begin
            if (match) begin
              we_o          = 1'b1;
              wdata_o.count = delay_q;
              ev_o.fin      = 1'b1;
              ev_o.act.vld  = (rdata_i.count == '0);
              ev_o.act.level = LEVEL_ON;
              ev_o.act.port = rdata_i.port;
              ev_o.act.pins = rdata_i.pins;
              state_d       = ST_IDLE;
              vld_d         = 1'b0;
            end
          end else begin
            if (rdata_i.count == '0) begin
              if (num_q < NUM_W'(MAX_RESULTS)) begin
                ev_o.act.vld   = 1'b1;
                ev_o.act.level = LEVEL_OFF;
                ev_o.act.port  = rdata_i.port;
                ev_o.act.pins  = rdata_i.pins;
                num_d          = num_q + NUM_W'(1);
              end
            end else begin
              we_o          = 1'b1;
              wdata_o.count = rdata_i.count - COUNT_W'(1);
            end
          end
        end else if (!issue) begin
          ev_o.fin = 1'b1;
          state_d  = ST_IDLE;
          if (func_q == FUNC_REQ && fill_q < FILL_W'(SLOTS)) begin
            we_o           = 1'b1;
            waddr_o        = fill_q[SLOT_AW-1:0];
            wdata_o.pins   = pins_q;
            wdata_o.port   = port_q;
            wdata_o.count  = delay_q;
            fill_d         = fill_q + FILL_W'(1);
            ev_o.act.vld   = 1'b1;
            ev_o.act.level = LEVEL_ON;
            ev_o.act.port  = port_q;
            ev_o.act.pins  = pins_q;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      fill_q  <= '0;
      num_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      fill_q  <= fill_d;
      num_q   <= num_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eidx_q  <= eidx_d;
    func_q  <= func_d;
    port_q  <= port_d;
    pins_q  <= pins_d;
    delay_q <= delay_d;
  end

endmodule

>>> src/ltt_out.sv
module ltt_out import ltt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ev_t               ev_i,
  output logic              res_strobe_o,
  output logic              drive_level_o,
  output logic [PORT_W-1:0] port_res_o,
  output logic [PINS_W-1:0] pin_mask_res_o,
  output logic              last_o
);

  act_t              pend_q, pend_d;
  logic              emit;
  act_t              emit_act;
  logic              emit_last;
  logic              strobe_q;
  level_e            level_q;
  logic [PORT_W-1:0] port_q;
  logic [PINS_W-1:0] pins_q;
  logic              last_q;

  // The newest off action is held back until the next one or the end of the
  // walk, so that the final word of a tick can be marked as last.
  always_comb begin
    emit      = 1'b0;
    emit_act  = ev_i.act;
    emit_last = 1'b0;
    pend_d    = pend_q;
    if (ev_i.fin) begin
      emit_last = 1'b1;
      pend_d.vld = 1'b0;
      if (ev_i.act.vld) begin
        emit = 1'b1;
      end else begin
        emit     = pend_q.vld;
        emit_act = pend_q;
      end
    end else if (ev_i.act.vld) begin
      emit     = pend_q.vld;
      emit_act = pend_q;
      pend_d   = ev_i.act;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      strobe_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= emit_act.level;
    port_q  <= emit_act.port;
    pins_q  <= emit_act.pins;
    last_q  <= emit_last;
  end

  assign res_strobe_o   = strobe_q;
  assign drive_level_o  = level_q;
  assign port_res_o     = port_q;
  assign pin_mask_res_o = pins_q;
  assign last_o         = last_q;

endmodule

>>> src/led_auto_off_timer_table.sv
// Table of retriggerable LED one-shot timers.
// Input channel: an item is taken at a rising edge with start high and busy
// low. With func_i low it is a turn-on request for the LED at port_i and
// pin_mask_i, lasting delay_i ticks; with func_i high it is a timer tick.
// A request with a zero pin mask is taken and ignored at once.
// Output channel: each action is one word on drive_level_o, port_res_o and
// pin_mask_res_o, valid for exactly one cycle while res_strobe_o is high.
// last_o marks the final word caused by an item. The receiver cannot stall;
// every word must be taken in the cycle it is shown.
// Timing: an item walks the filled slots through the slot memory, one slot
// read per cycle, with a registered read. A tick or an unmatched request
// keeps busy high while it reads and checks every filled slot and until the
// walk then ends. A request that matches keeps busy high up to the cycle
// after it reads the matching slot. Each off word is held back until the
// next one or the end of the walk, and the final word of an item shows in
// the cycle right after busy falls.
// Reset empties the table through a fill count, with no clearing pass; the
// block accepts items in the first cycle after reset.
module led_auto_off_timer_table import ltt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               func_i,
  input  logic [PORT_W-1:0]  port_i,
  input  logic [PINS_W-1:0]  pin_mask_i,
  input  logic [COUNT_W-1:0] delay_i,
  output logic               res_strobe_o,
  output logic               drive_level_o,
  output logic [PORT_W-1:0]  port_res_o,
  output logic [PINS_W-1:0]  pin_mask_res_o,
  output logic               last_o
);

  logic               re;
  logic [SLOT_AW-1:0] raddr;
  entry_t             rdata;
  logic               we;
  logic [SLOT_AW-1:0] waddr;
  entry_t             wdata;
  ev_t                ev;

  ltt_ram #(
    .Width (ENTRY_W),
    .Depth (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ltt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .func_i     (func_i),
    .port_i     (port_i),
    .pin_mask_i (pin_mask_i),
    .delay_i    (delay_i),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .ev_o       (ev)
  );

  ltt_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ev_i           (ev),
    .res_strobe_o   (res_strobe_o),
    .drive_level_o  (drive_level_o),
    .port_res_o     (port_res_o),
    .pin_mask_res_o (pin_mask_res_o),
    .last_o         (last_o)
  );

endmodule

>>> src/ltt_checker.sv
module ltt_checker import ltt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               func_i,
  input logic [PINS_W-1:0]  pin_mask_i,
  input logic               res_strobe_o,
  input logic               drive_level_o,
  input logic [PINS_W-1:0]  pin_mask_res_o,
  input logic               last_o
);

  // A turn-on word is the only word of its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && drive_level_o == LEVEL_ON |-> last_o)
    else $error("turn-on word not marked last");

  // Slots never hold an empty pin mask, so no word drives zero pins.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> pin_mask_res_o != '0)
    else $error("word with empty pin mask");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && func_i == FUNC_REQ && pin_mask_i == '0 |=> !busy)
    else $error("ignored request made the block busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (func_i == FUNC_TICK || pin_mask_i != '0) |=> busy)
    else $error("accepted word did not raise busy");

endmodule

bind led_auto_off_timer_table ltt_checker u_ltt_checker (.*);
